/* src/rlse_pkg.sv */
// shared types and constants for the rgb led spi symbol encoder
package rlse_pkg;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 9;
    localparam int BRIGHT_W = 9;
    localparam int CHAN_W = 8;
    localparam int NUM_LANES = 3;
    localparam int PIX_BITS = NUM_LANES * CHAN_W;
    localparam int CNT_W = 5;

    localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_SYMBOL   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_SYMBOL  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_LENGTH = 2'd3;

    localparam logic [BRIGHT_W-1:0] BRIGHTNESS_RST   = 9'd150;
    localparam logic [7:0]          ONE_SYMBOL_RST   = 8'hFC;
    localparam logic [7:0]          ZERO_SYMBOL_RST  = 8'h80;
    localparam logic [7:0]          RESET_LENGTH_RST = 8'd100;

    localparam logic [CNT_W-1:0] LAST_DATA_SLOT = 5'd23;
    localparam logic [CNT_W-1:0] GAP_SLOT       = 5'd24;
    localparam logic [7:0]       GAP_BYTE       = 8'h00;
    localparam logic [7:0]       DATA_REPEAT    = 8'd1;

    typedef struct packed {
        logic [7:0] one_symbol;
        logic [7:0] zero_symbol;
        logic [7:0] reset_length;
    } rlse_cfg_t;

endpackage

/* src/rlse_lane.sv */
// one color lane: brightness scaling of a channel byte into a register
module rlse_lane
(
    input  logic                          clk,
    input  logic                          load,
    input  logic [rlse_pkg::CHAN_W-1:0]   channel,
    input  logic [rlse_pkg::BRIGHT_W-1:0] brightness,
    output logic [rlse_pkg::CHAN_W-1:0]   scaled
);
    import rlse_pkg::*;

    logic [CHAN_W+BRIGHT_W-1:0] product;
    logic [CHAN_W-1:0]          scaled_reg;

    assign product = {{BRIGHT_W{1'b0}}, channel} * {{CHAN_W{1'b0}}, brightness};

    // keep bits 15..8, wraps when channel times brightness needs more than 16 bits (brightness above 257)
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            scaled_reg <= product[2*CHAN_W-1:CHAN_W];
        end
    end

    assign scaled = scaled_reg;

endmodule

/* src/rlse_merge.sv */
// merging serializer: turns the lane bytes into symbol words and the latch gap word
module rlse_merge
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  rlse_pkg::rlse_cfg_t             cfg,
    input  logic                            load_valid,
    input  logic [rlse_pkg::PIX_BITS-1:0]   load_bits,
    input  logic                            load_gap,
    output logic                            load_ready,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [7:0]                      spi_byte,
    output logic [7:0]                      repeat_count,
    output logic                            last_of_run
);
    import rlse_pkg::*;

    logic                active_reg, active_next;
    logic [PIX_BITS-1:0] bits_reg, bits_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                gap_reg, gap_next;
    logic                valid_reg, valid_next;
    logic [7:0]          byte_reg, byte_next;
    logic [7:0]          rep_reg, rep_next;
    logic                last_reg, last_next;

    logic out_free;
    logic emit;
    logic finishing;
    logic load;

    assign out_free   = !valid_reg || out_ready;
    assign emit       = active_reg && out_free;
    assign finishing  = emit && (((cnt_reg == LAST_DATA_SLOT) && !gap_reg)
                                 || (cnt_reg == GAP_SLOT));
    assign load_ready = !active_reg || finishing;
    assign load       = load_valid && load_ready;

    always_comb
    begin
        active_next = active_reg;
        bits_next   = bits_reg;
        cnt_next    = cnt_reg;
        gap_next    = gap_reg;
        valid_next  = valid_reg;
        byte_next   = byte_reg;
        rep_next    = rep_reg;
        last_next   = last_reg;

        if (out_free)
        begin
            valid_next = emit;
        end

        if (emit)
        begin
            if (cnt_reg == GAP_SLOT)
            begin
                byte_next = GAP_BYTE;
                rep_next  = cfg.reset_length;
                last_next = 1'b1;
            end
            else
            begin
                byte_next = bits_reg[PIX_BITS-1] ? cfg.one_symbol : cfg.zero_symbol;
                rep_next  = DATA_REPEAT;
                last_next = (cnt_reg == LAST_DATA_SLOT) && !gap_reg;
            end
            bits_next = {bits_reg[PIX_BITS-2:0], 1'b0};
            cnt_next  = cnt_reg + 1'b1;
            if (finishing)
            begin
                active_next = 1'b0;
            end
        end

        if (load)
        begin
            active_next = 1'b1;
            bits_next   = load_bits;
            cnt_next    = '0;
            gap_next    = load_gap;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            valid_reg  <= 1'b0;
            cnt_reg    <= '0;
            gap_reg    <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            valid_reg  <= valid_next;
            cnt_reg    <= cnt_next;
            gap_reg    <= gap_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bits_reg <= bits_next;
        byte_reg <= byte_next;
        rep_reg  <= rep_next;
        last_reg <= last_next;
    end

    assign out_valid    = valid_reg;
    assign spi_byte     = byte_reg;
    assign repeat_count = rep_reg;
    assign last_of_run  = last_reg;

endmodule

/* src/rgb_led_spi_symbol_encoder.sv */
// top level of the rgb led spi symbol encoder
// path: an accepted pixel passes the lane registers, the serializer shift register and the output word register
// throughput: one word per cycle while out_ready holds, 24 words per pixel, 25 when the latch gap word follows
// the serializer sets the rate; the three lane registers take the next pixel meanwhile
// reset: rst_n clears all handshake state and loads the config registers with their defaults
module rgb_led_spi_symbol_encoder
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [rlse_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rlse_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [7:0]                        red,
    input  logic [7:0]                        green,
    input  logic [7:0]                        blue,
    input  logic                              last_pixel,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [7:0]                        spi_byte,
    output logic [7:0]                        repeat_count,
    output logic                              last_of_run
);
    import rlse_pkg::*;

    logic [BRIGHT_W-1:0] brightness_reg;
    logic [7:0]          one_symbol_reg;
    logic [7:0]          zero_symbol_reg;
    logic [7:0]          reset_length_reg;
    rlse_cfg_t           cfg;

    logic          pix_valid_reg, pix_valid_next;
    logic          pix_gap_reg;
    logic          in_fire;
    logic          load_ready;
    logic [7:0]    green_s, red_s, blue_s;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_reg   <= BRIGHTNESS_RST;
            one_symbol_reg   <= ONE_SYMBOL_RST;
            zero_symbol_reg  <= ZERO_SYMBOL_RST;
            reset_length_reg <= RESET_LENGTH_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_BRIGHTNESS:   brightness_reg   <= cfg_data;
                REG_ONE_SYMBOL:   one_symbol_reg   <= cfg_data[7:0];
                REG_ZERO_SYMBOL:  zero_symbol_reg  <= cfg_data[7:0];
                REG_RESET_LENGTH: reset_length_reg <= cfg_data[7:0];
            endcase
        end
    end

    assign cfg = {one_symbol_reg, zero_symbol_reg, reset_length_reg};

    // pixel stage in front of the serializer
    assign in_ready = !pix_valid_reg || load_ready;
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        pix_valid_next = pix_valid_reg;
        if (in_fire)
        begin
            pix_valid_next = 1'b1;
        end
        else if (load_ready)
        begin
            pix_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_valid_reg <= 1'b0;
        end
        else
        begin
            pix_valid_reg <= pix_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            pix_gap_reg <= last_pixel && (reset_length_reg != 8'd0);
        end
    end

    rlse_lane u_lane_green
    (
        .clk        (clk),
        .load       (in_fire),
        .channel    (green),
        .brightness (brightness_reg),
        .scaled     (green_s)
    );

    rlse_lane u_lane_red
    (
        .clk        (clk),
        .load       (in_fire),
        .channel    (red),
        .brightness (brightness_reg),
        .scaled     (red_s)
    );

    rlse_lane u_lane_blue
    (
        .clk        (clk),
        .load       (in_fire),
        .channel    (blue),
        .brightness (brightness_reg),
        .scaled     (blue_s)
    );

    rlse_merge u_merge
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .load_valid   (pix_valid_reg),
        .load_bits    ({green_s, red_s, blue_s}),
        .load_gap     (pix_gap_reg),
        .load_ready   (load_ready),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .spi_byte     (spi_byte),
        .repeat_count (repeat_count),
        .last_of_run  (last_of_run)
    );

endmodule

/* src/rlse_checker.sv */
// port-level checks for the rgb led spi symbol encoder
module rlse_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] spi_byte,
    input logic [7:0] repeat_count,
    input logic       last_of_run
);

    // stalled word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(spi_byte)
            && $stable(repeat_count) && $stable(last_of_run))
        else $error("output word changed while stalled");

    // only the gap word repeats more than once
    a_gap_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && repeat_count != 8'd1 |-> last_of_run && spi_byte == 8'h00)
        else $error("repeated word is not a gap word");

    a_no_zero_repeat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> repeat_count != 8'd0)
        else $error("word with zero repeat count");

    // words of one pixel come without bubbles
    a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_of_run |=> out_valid)
        else $error("gap inside a pixel run");

endmodule

bind rgb_led_spi_symbol_encoder rlse_checker u_rlse_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .spi_byte     (spi_byte),
    .repeat_count (repeat_count),
    .last_of_run  (last_of_run)
);

/* sim/rgb_led_spi_symbol_encoder_tb.sv */
// self-checking testbench for the rgb led spi symbol encoder
module rgb_led_spi_symbol_encoder_tb;
    import rlse_pkg::*;

    localparam int N_DIR = 18;
    localparam int RANDOM_PIXELS = 300;
    localparam int STALL_LIMIT = 4000;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last_pixel;
    } pixel_t;

    typedef struct packed {
        logic [7:0] spi_byte;
        logic [7:0] repeat_count;
        logic       last_of_run;
    } sym_word_t;

    typedef struct packed {
        bit                  cfg_en;
        logic [BRIGHT_W-1:0] bright;
        logic [7:0]          one_sym;
        logic [7:0]          zero_sym;
        logic [7:0]          gap_len;
        pixel_t              pix;
        bit                  typed;
        logic [PIX_BITS-1:0] grb;
    } dir_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [7:0]           red = '0;
    logic [7:0]           green = '0;
    logic [7:0]           blue = '0;
    logic                 last_pixel = 1'b0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [7:0]           spi_byte;
    logic [7:0]           repeat_count;
    logic                 last_of_run;

    // register copies used for prediction
    logic [BRIGHT_W-1:0] bright_r = BRIGHTNESS_RST;
    logic [7:0]          one_sym_r = ONE_SYMBOL_RST;
    logic [7:0]          zero_sym_r = ZERO_SYMBOL_RST;
    logic [7:0]          gap_len_r = RESET_LENGTH_RST;

    sym_word_t symbol_words_q [$];

    int errors = 0;
    int pixels_sent = 0;
    int frame_ends = 0;
    int words_checked = 0;
    int cfg_sets = 0;
    int burst_left = 0;
    bit steady = 1'b0;
    int stall_cycles = 0;
    int rx_cycle = 0;
    int rx_mode = 0;

    // scaled values typed in only where they are obvious
    dir_row_t dir_rows [N_DIR] = '{
        '{1'b0, 9'd0,   8'h00, 8'h00, 8'd0,   '{8'd255, 8'd255, 8'd255, 1'b0}, 1'b1, 24'h959595},
        '{1'b0, 9'd0,   8'h00, 8'h00, 8'd0,   '{8'd0,   8'd0,   8'd0,   1'b1}, 1'b1, 24'h000000},
        '{1'b1, 9'd256, 8'hFC, 8'h80, 8'd100, '{8'd255, 8'd0,   8'd0,   1'b0}, 1'b1, 24'h00FF00},
        '{1'b0, 9'd0,   8'h00, 8'h00, 8'd0,   '{8'd0,   8'd255, 8'd170, 1'b1}, 1'b1, 24'hFF00AA},
        '{1'b1, 9'd0,   8'hFF, 8'h00, 8'd0,   '{8'd255, 8'd255, 8'd255, 1'b1}, 1'b1, 24'h000000},
        '{1'b0, 9'd0,   8'h00, 8'h00, 8'd0,   '{8'd18,  8'd52,  8'd200, 1'b0}, 1'b0, 24'h000000},
        '{1'b1, 9'd511, 8'h00, 8'hFF, 8'd255, '{8'd255, 8'd255, 8'd255, 1'b1}, 1'b1, 24'hFDFDFD},
        '{1'b0, 9'd0,   8'h00, 8'h00, 8'd0,   '{8'd1,   8'd2,   8'd128, 1'b0}, 1'b1, 24'h0301FF},
        '{1'b1, 9'd257, 8'hAA, 8'h55, 8'd1,   '{8'd255, 8'd128, 8'd1,   1'b1}, 1'b1, 24'h80FF01},
        '{1'b1, 9'd300, 8'h5A, 8'hA5, 8'd37,  '{8'd255, 8'd100, 8'd77,  1'b1}, 1'b0, 24'h000000},
        '{1'b0, 9'd0,   8'h00, 8'h00, 8'd0,   '{8'd128, 8'd64,  8'd32,  1'b0}, 1'b0, 24'h000000},
        '{1'b1, 9'd1,   8'hFF, 8'h00, 8'd200, '{8'd255, 8'd255, 8'd255, 1'b0}, 1'b1, 24'h000000},
        '{1'b0, 9'd0,   8'h00, 8'h00, 8'd0,   '{8'd200, 8'd3,   8'd99,  1'b1}, 1'b0, 24'h000000},
        '{1'b1, 9'd128, 8'h0F, 8'hF0, 8'd0,   '{8'd170, 8'd85,  8'd255, 1'b1}, 1'b0, 24'h000000},
        '{1'b0, 9'd0,   8'h00, 8'h00, 8'd0,   '{8'd255, 8'd0,   8'd255, 1'b0}, 1'b0, 24'h000000},
        '{1'b1, 9'd255, 8'h33, 8'hCC, 8'd5,   '{8'd37,  8'd250, 8'd111, 1'b1}, 1'b0, 24'h000000},
        '{1'b0, 9'd0,   8'h00, 8'h00, 8'd0,   '{8'd255, 8'd255, 8'd255, 1'b0}, 1'b1, 24'hFEFEFE},
        '{1'b0, 9'd0,   8'h00, 8'h00, 8'd0,   '{8'd0,   8'd0,   8'd0,   1'b1}, 1'b1, 24'h000000}
    };

    rgb_led_spi_symbol_encoder dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .last_pixel   (last_pixel),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .spi_byte     (spi_byte),
        .repeat_count (repeat_count),
        .last_of_run  (last_of_run)
    );

    always #6 clk = ~clk;

    function automatic logic [7:0] scale_channel(input logic [7:0] chan);
        logic [16:0] prod;
        prod = chan * bright_r;
        return prod[15:8];
    endfunction

    function automatic logic [7:0] rand_channel();
        case ($urandom_range(0, 7))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // 24 symbol words msb first, then the latch gap word when enabled
    task automatic queue_symbol_words(input logic [PIX_BITS-1:0] grb, input logic is_last);
        sym_word_t w;
        bit gap;
        gap = is_last && (gap_len_r != 8'd0);
        for (int i = PIX_BITS - 1; i >= 0; i--)
        begin
            w.spi_byte = grb[i] ? one_sym_r : zero_sym_r;
            w.repeat_count = DATA_REPEAT;
            w.last_of_run = !gap && (i == 0);
            symbol_words_q.push_back(w);
        end
        if (gap)
        begin
            w.spi_byte = GAP_BYTE;
            w.repeat_count = gap_len_r;
            w.last_of_run = 1'b1;
            symbol_words_q.push_back(w);
        end
    endtask

    task automatic send_pixel(input pixel_t p, input bit typed, input logic [PIX_BITS-1:0] grb);
        in_valid <= 1'b1;
        red <= p.red;
        green <= p.green;
        blue <= p.blue;
        last_pixel <= p.last_pixel;
        do
            @(posedge clk);
        while (!in_ready);
        if (typed)
            queue_symbol_words(grb, p.last_pixel);
        else
            queue_symbol_words({scale_channel(p.green), scale_channel(p.red),
                                scale_channel(p.blue)}, p.last_pixel);
        pixels_sent++;
        if (p.last_pixel)
            frame_ends++;
    endtask

    task automatic hold_off(input int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic drain_words();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (symbol_words_q.size() != 0);
    endtask

    task automatic set_config(input logic [BRIGHT_W-1:0] b, input logic [7:0] o,
                              input logic [7:0] z, input logic [7:0] g);
        logic [CFG_IDX_W-1:0]  idxs [4];
        logic [CFG_DATA_W-1:0] vals [4];
        idxs = '{REG_BRIGHTNESS, REG_ONE_SYMBOL, REG_ZERO_SYMBOL, REG_RESET_LENGTH};
        vals = '{b, {1'b0, o}, {1'b0, z}, {1'b0, g}};
        for (int k = 0; k < 4; k++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= idxs[k];
            cfg_data <= vals[k];
            @(posedge clk);
        end
        cfg_write <= 1'b0;
        bright_r = b;
        one_sym_r = o;
        zero_sym_r = z;
        gap_len_r = g;
        cfg_sets++;
    endtask

    task automatic pace_sender();
        if ($urandom_range(0, 40) == 0)
            drain_words();
        else if (!steady)
        begin
            if (burst_left > 0)
                burst_left--;
            else
            begin
                hold_off($urandom_range(1, 16));
                burst_left = $urandom_range(0, 9);
            end
        end
    endtask

    task automatic check_word();
        sym_word_t exp_w;
        if (symbol_words_q.size() == 0)
        begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("unexpected word: byte %h rep %0d last %b",
                         spi_byte, repeat_count, last_of_run);
        end
        else
        begin
            exp_w = symbol_words_q.pop_front();
            if (spi_byte !== exp_w.spi_byte || repeat_count !== exp_w.repeat_count ||
                last_of_run !== exp_w.last_of_run)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("mismatch at word %0d: expected byte %h rep %0d last %b, got byte %h rep %0d last %b",
                             words_checked, exp_w.spi_byte, exp_w.repeat_count,
                             exp_w.last_of_run, spi_byte, repeat_count, last_of_run);
            end
            words_checked++;
        end
    endtask

    // receiver with its own stall patterns
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_cycle <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
                check_word();
            rx_cycle <= rx_cycle + 1;
            if (rx_cycle % 200 == 0)
                rx_mode <= $urandom_range(0, 3);
            case (rx_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= 1'($urandom_range(0, 1));
                2: out_ready <= (rx_cycle % 4 == 0);
                default: out_ready <= (rx_cycle % 16) < 11;
            endcase
        end
    end

    // watchdog on cycles without any accepted word or pixel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("timeout after %0d cycles without progress", stall_cycles);
                $display("FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        pixel_t p;
        int random_sent;
        int phase_len;
        logic [BRIGHT_W-1:0] b;
        logic [7:0] o;
        logic [7:0] z;
        logic [7:0] g;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIR; i++)
        begin
            if (dir_rows[i].cfg_en)
            begin
                drain_words();
                set_config(dir_rows[i].bright, dir_rows[i].one_sym,
                           dir_rows[i].zero_sym, dir_rows[i].gap_len);
            end
            send_pixel(dir_rows[i].pix, dir_rows[i].typed, dir_rows[i].grb);
            pace_sender();
        end

        random_sent = 0;
        while (random_sent < RANDOM_PIXELS)
        begin
            drain_words();
            case ($urandom_range(0, 7))
                0: b = 9'd0;
                1: b = 9'd256;
                2: b = 9'd511;
                3: b = 9'd1;
                4: b = 9'd255;
                default: b = 9'($urandom_range(0, 511));
            endcase
            if ($urandom_range(0, 3) == 0)
            begin
                o = 8'hFF;
                z = 8'h00;
            end
            else
            begin
                o = 8'($urandom_range(0, 255));
                z = 8'($urandom_range(0, 255));
            end
            case ($urandom_range(0, 5))
                0: g = 8'd0;
                1: g = 8'd255;
                2: g = 8'd1;
                default: g = 8'($urandom_range(0, 255));
            endcase
            set_config(b, o, z, g);
            steady = ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(15, 45);
            for (int k = 0; k < phase_len; k++)
            begin
                p.red = rand_channel();
                p.green = rand_channel();
                p.blue = rand_channel();
                p.last_pixel = ($urandom_range(0, 7) == 0) || (k == phase_len - 1);
                send_pixel(p, 1'b0, '0);
                random_sent++;
                pace_sender();
            end
        end

        drain_words();
        repeat (8) @(posedge clk);
        if (symbol_words_q.size() != 0)
        begin
            errors += symbol_words_q.size();
            $display("%0d expected words never arrived", symbol_words_q.size());
        end
        $display("covered %0d pixels in %0d frames, %0d register settings",
                 pixels_sent, frame_ends, cfg_sets);
        $display("checked %0d symbol words, %0d errors", words_checked, errors);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
